>>> hdl/ewcs_pkg.sv
// Shared types, codes and field widths of the echo-wave clock sync node.
// No dependencies; every module of the block refers to it by scoped names.
package ewcs_pkg;

    localparam int CLK_W      = 32;
    localparam int SUM_W      = 40;
    localparam int NODE_W     = 16;
    localparam int PORT_W     = 4;
    localparam int CNT_W      = 5;
    localparam int INC_W      = 17;
    localparam int FRAC_BITS  = 16;
    localparam int MAX_PORTS  = 16;
    localparam int DIVIDEND_W = SUM_W + 1;
    localparam int DIVCNT_W   = 6;

    // input commands
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_TIMER = 3'd1;
    localparam logic [2:0] CMD_EXPL  = 3'd2;
    localparam logic [2:0] CMD_ECHO  = 3'd3;
    localparam logic [2:0] CMD_SYNC  = 3'd4;

    // result kinds
    localparam logic [2:0] KIND_CLOCK   = 3'd0;
    localparam logic [2:0] KIND_EXPL    = 3'd1;
    localparam logic [2:0] KIND_ECHO    = 3'd2;
    localparam logic [2:0] KIND_SYNC    = 3'd3;
    localparam logic [2:0] KIND_VERDICT = 3'd4;
    localparam logic [2:0] KIND_DIVERR  = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_IS_SINK     = 2'd0;
    localparam logic [1:0] REG_NEIGHBORS   = 2'd1;
    localparam logic [1:0] REG_TOTAL_NODES = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TICK,
        ST_FLOOD,
        ST_CHECK,
        ST_COMPLETE,
        ST_ERR,
        ST_DIV
    } state_t;

    typedef enum logic [1:0] {
        FL_TIMER,
        FL_EXPL,
        FL_SYNC,
        FL_AVG
    } flood_t;

    typedef enum logic [2:0] {
        EM_CLOCK,
        EM_FLOOD,
        EM_ECHO,
        EM_VERDICT,
        EM_DIVERR
    } emit_t;

    typedef struct packed {
        logic   load_in;
        logic   exec;
        logic   flood_init;
        logic   flood_adv;
        flood_t flood_mode;
        logic   emit;
        emit_t  emit_sel;
        logic   emit_last;
        logic   div_start;
        logic   apply_avg;
        logic   wave_clear;
    } ewcs_cmd_t;

    typedef struct packed {
        logic [2:0] in_cmd;
        logic       is_sink;
        logic       wave_reached;
        logic       sync_done;
        logic       resp_hit;
        logic       flood_empty;
        logic       flood_skip;
        logic       flood_at_last;
        logic       div_zero;
        logic       div_busy;
        logic       out_free;
    } ewcs_stat_t;

endpackage

>>> hdl/ewcs_ctrl.sv
// Sequencer of the echo-wave clock sync node: walks one transaction through
// decode, floods, wave completion and division. Depends on ewcs_pkg.
module ewcs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  ewcs_pkg::ewcs_stat_t st,
    output ewcs_pkg::ewcs_cmd_t  cmd
);

    ewcs_pkg::state_t state_reg, state_next;
    ewcs_pkg::flood_t mode_reg, mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ewcs_pkg::ST_IDLE;
            mode_reg  <= ewcs_pkg::FL_TIMER;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        s_tready       = 1'b0;
        cmd            = '0;
        cmd.flood_mode = mode_reg;
        case (state_reg)
            ewcs_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ewcs_pkg::ST_DECODE;
                end
            end
            ewcs_pkg::ST_DECODE:
            begin
                cmd.exec       = 1'b1;
                cmd.flood_init = 1'b1;
                state_next     = ewcs_pkg::ST_IDLE;
                case (st.in_cmd)
                    ewcs_pkg::CMD_TICK:
                        state_next = ewcs_pkg::ST_TICK;
                    ewcs_pkg::CMD_TIMER:
                    begin
                        if (st.is_sink)
                        begin
                            mode_next  = ewcs_pkg::FL_TIMER;
                            state_next = ewcs_pkg::ST_FLOOD;
                        end
                    end
                    ewcs_pkg::CMD_EXPL:
                    begin
                        if (!st.wave_reached)
                        begin
                            mode_next  = ewcs_pkg::FL_EXPL;
                            state_next = ewcs_pkg::ST_FLOOD;
                        end
                        else
                            state_next = ewcs_pkg::ST_CHECK;
                    end
                    ewcs_pkg::CMD_ECHO:
                        state_next = ewcs_pkg::ST_CHECK;
                    ewcs_pkg::CMD_SYNC:
                    begin
                        if (!st.is_sink && !st.sync_done)
                        begin
                            mode_next  = ewcs_pkg::FL_SYNC;
                            state_next = ewcs_pkg::ST_FLOOD;
                        end
                    end
                    default:
                        state_next = ewcs_pkg::ST_IDLE;
                endcase
            end
            ewcs_pkg::ST_TICK:
            begin
                if (st.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = ewcs_pkg::EM_CLOCK;
                    cmd.emit_last = 1'b1;
                    state_next    = ewcs_pkg::ST_IDLE;
                end
            end
            ewcs_pkg::ST_FLOOD:
            begin
                if (st.flood_empty)
                    state_next = ewcs_pkg::ST_CHECK;
                else if (st.flood_skip)
                    cmd.flood_adv = 1'b1;
                else if (st.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = ewcs_pkg::EM_FLOOD;
                    if (mode_reg == ewcs_pkg::FL_EXPL)
                        cmd.emit_last = st.flood_at_last && !st.resp_hit;
                    else
                        cmd.emit_last = st.flood_at_last;
                    if (st.flood_at_last)
                    begin
                        if (mode_reg == ewcs_pkg::FL_EXPL)
                            state_next = ewcs_pkg::ST_CHECK;
                        else
                            state_next = ewcs_pkg::ST_IDLE;
                        if (mode_reg == ewcs_pkg::FL_AVG)
                        begin
                            cmd.apply_avg  = 1'b1;
                            cmd.wave_clear = 1'b1;
                        end
                    end
                    else
                        cmd.flood_adv = 1'b1;
                end
            end
            ewcs_pkg::ST_CHECK:
            begin
                if (st.resp_hit)
                    state_next = ewcs_pkg::ST_COMPLETE;
                else
                    state_next = ewcs_pkg::ST_IDLE;
            end
            ewcs_pkg::ST_COMPLETE:
            begin
                if (st.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (!st.is_sink)
                    begin
                        cmd.emit_sel   = ewcs_pkg::EM_ECHO;
                        cmd.emit_last  = 1'b1;
                        cmd.wave_clear = 1'b1;
                        state_next     = ewcs_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.emit_sel = ewcs_pkg::EM_VERDICT;
                        if (st.div_zero)
                            state_next = ewcs_pkg::ST_ERR;
                        else
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = ewcs_pkg::ST_DIV;
                        end
                    end
                end
            end
            ewcs_pkg::ST_ERR:
            begin
                if (st.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_sel   = ewcs_pkg::EM_DIVERR;
                    cmd.emit_last  = 1'b1;
                    cmd.wave_clear = 1'b1;
                    state_next     = ewcs_pkg::ST_IDLE;
                end
            end
            ewcs_pkg::ST_DIV:
            begin
                if (!st.div_busy)
                begin
                    cmd.flood_init = 1'b1;
                    mode_next      = ewcs_pkg::FL_AVG;
                    state_next     = ewcs_pkg::ST_FLOOD;
                end
            end
            default:
                state_next = ewcs_pkg::ST_IDLE;
        endcase
    end

endmodule

>>> hdl/ewcs_dpath.sv
// Datapath of the echo-wave clock sync node: protocol state, configuration,
// serial divider and output register. Depends on ewcs_pkg.
module ewcs_dpath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_addr,
    input  logic [15:0]          cfg_wdata,
    input  logic [2:0]           s_tuser,
    input  logic [111:0]         s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,
    output logic [2:0]           m_tuser,
    output logic                 m_tlast,
    input  ewcs_pkg::ewcs_cmd_t  cmd,
    output ewcs_pkg::ewcs_stat_t st
);

    // configuration
    logic                        is_sink_reg;
    logic [ewcs_pkg::CNT_W-1:0]  nbr_reg;
    logic [ewcs_pkg::NODE_W-1:0] total_reg;

    // latched transaction
    logic [2:0]                   in_cmd_reg;
    logic [ewcs_pkg::PORT_W-1:0]  in_port_reg;
    logic [ewcs_pkg::INC_W-1:0]   in_inc_reg;
    logic [ewcs_pkg::SUM_W-1:0]   in_eclk_reg;
    logic [ewcs_pkg::NODE_W-1:0]  in_enodes_reg;
    logic [ewcs_pkg::CLK_W-1:0]   in_sclk_reg;

    // protocol state
    logic [ewcs_pkg::CLK_W-1:0]  local_clock_reg;
    logic [ewcs_pkg::SUM_W-1:0]  sum_reg;
    logic [ewcs_pkg::NODE_W-1:0] desc_reg;
    logic                        wave_reg;
    logic [ewcs_pkg::CNT_W-1:0]  resp_reg;
    logic [ewcs_pkg::PORT_W-1:0] parent_reg;
    logic                        sync_done_reg;
    logic [ewcs_pkg::CNT_W-1:0]  sync_seen_reg;

    logic [ewcs_pkg::PORT_W-1:0] fport_reg;

    // divider
    logic                            div_busy_reg;
    logic [ewcs_pkg::DIVCNT_W-1:0]   div_cnt_reg;
    logic [ewcs_pkg::NODE_W-1:0]     rem_reg;
    logic [ewcs_pkg::DIVIDEND_W-1:0] quo_reg;
    logic [ewcs_pkg::NODE_W:0]       trial;
    logic [ewcs_pkg::NODE_W:0]       divisor;
    logic                            trial_ge;
    logic [ewcs_pkg::CLK_W-1:0]      avg;

    logic [ewcs_pkg::CNT_W-1:0]  n;
    logic [ewcs_pkg::CNT_W-1:0]  last_port;
    logic [ewcs_pkg::INC_W-1:0]  inc_clamped;
    logic [ewcs_pkg::CLK_W:0]    tick_sum;
    logic [ewcs_pkg::SUM_W:0]    echo_sum;
    logic [ewcs_pkg::SUM_W:0]    wave_total;
    logic [ewcs_pkg::SUM_W:0]    child_sum;
    logic [ewcs_pkg::CNT_W-1:0]  resp_inc;
    logic [ewcs_pkg::CNT_W-1:0]  seen_inc;
    logic [ewcs_pkg::NODE_W:0]   desc_plus;
    logic                        is_expl_mode;

    logic [2:0]                  o_kind;
    logic [ewcs_pkg::PORT_W-1:0] o_port;
    logic [ewcs_pkg::SUM_W-1:0]  o_clock;
    logic [ewcs_pkg::NODE_W-1:0] o_nodes;
    logic                        o_conn;

    always_comb
    begin
        if (nbr_reg == '0)
            n = ewcs_pkg::CNT_W'(1);
        else if (nbr_reg > ewcs_pkg::CNT_W'(ewcs_pkg::MAX_PORTS))
            n = ewcs_pkg::CNT_W'(ewcs_pkg::MAX_PORTS);
        else
            n = nbr_reg;
    end

    assign is_expl_mode = (cmd.flood_mode == ewcs_pkg::FL_EXPL);
    assign last_port = (is_expl_mode && {1'b0, parent_reg} == n - 1'b1)
                       ? n - ewcs_pkg::CNT_W'(2) : n - 1'b1;

    assign inc_clamped = (in_inc_reg > ewcs_pkg::INC_W'(1 << ewcs_pkg::FRAC_BITS))
                         ? ewcs_pkg::INC_W'(1 << ewcs_pkg::FRAC_BITS) : in_inc_reg;
    assign tick_sum   = {1'b0, local_clock_reg} + (ewcs_pkg::CLK_W+1)'(inc_clamped);
    assign child_sum  = {1'b0, sum_reg} + {1'b0, in_eclk_reg};
    assign wave_total = {1'b0, sum_reg} + (ewcs_pkg::SUM_W+1)'(local_clock_reg);
    assign echo_sum   = wave_total;
    assign resp_inc   = resp_reg + 1'b1;
    assign seen_inc   = sync_seen_reg + 1'b1;
    assign desc_plus  = {1'b0, desc_reg} + 1'b1;

    assign divisor  = {1'b0, desc_reg} + 1'b1;
    assign trial    = {rem_reg, quo_reg[ewcs_pkg::DIVIDEND_W-1]};
    assign trial_ge = (trial >= divisor);
    assign avg = (quo_reg[ewcs_pkg::DIVIDEND_W-1:ewcs_pkg::CLK_W] != '0)
                 ? '1 : quo_reg[ewcs_pkg::CLK_W-1:0];

    always_comb
    begin
        st               = '0;
        st.in_cmd        = in_cmd_reg;
        st.is_sink       = is_sink_reg;
        st.wave_reached  = wave_reg;
        st.sync_done     = sync_done_reg;
        st.resp_hit      = (resp_reg == n);
        st.flood_empty   = is_expl_mode && (n == ewcs_pkg::CNT_W'(1)) && (parent_reg == '0);
        st.flood_skip    = is_expl_mode && (fport_reg == parent_reg);
        st.flood_at_last = ({1'b0, fport_reg} == last_port);
        st.div_zero      = (desc_reg == '1);
        st.div_busy      = div_busy_reg;
        st.out_free      = !m_tvalid || m_tready;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_sink_reg <= 1'b0;
            nbr_reg     <= ewcs_pkg::CNT_W'(1);
            total_reg   <= ewcs_pkg::NODE_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                ewcs_pkg::REG_IS_SINK:     is_sink_reg <= cfg_wdata[0];
                ewcs_pkg::REG_NEIGHBORS:   nbr_reg     <= cfg_wdata[ewcs_pkg::CNT_W-1:0];
                ewcs_pkg::REG_TOTAL_NODES: total_reg   <= cfg_wdata;
                default:                   ;
            endcase
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_cmd_reg    <= s_tuser;
            in_port_reg   <= s_tdata[3:0];
            in_inc_reg    <= s_tdata[20:4];
            in_eclk_reg   <= s_tdata[60:21];
            in_enodes_reg <= s_tdata[76:61];
            in_sclk_reg   <= s_tdata[108:77];
        end
    end

    // protocol state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_clock_reg <= '0;
            sum_reg         <= '0;
            desc_reg        <= '0;
            wave_reg        <= 1'b0;
            resp_reg        <= '0;
            parent_reg      <= '0;
            sync_done_reg   <= 1'b0;
            sync_seen_reg   <= '0;
            fport_reg       <= '0;
        end
        else
        begin
            if (cmd.exec)
            begin
                case (in_cmd_reg)
                    ewcs_pkg::CMD_TICK:
                        local_clock_reg <= tick_sum[ewcs_pkg::CLK_W] ? '1
                                           : tick_sum[ewcs_pkg::CLK_W-1:0];
                    ewcs_pkg::CMD_TIMER:
                    begin
                        if (is_sink_reg)
                            wave_reg <= 1'b1;
                    end
                    ewcs_pkg::CMD_EXPL:
                    begin
                        resp_reg <= resp_inc;
                        if (!wave_reg)
                        begin
                            wave_reg   <= 1'b1;
                            parent_reg <= in_port_reg;
                        end
                    end
                    ewcs_pkg::CMD_ECHO:
                    begin
                        resp_reg <= resp_inc;
                        desc_reg <= desc_plus[ewcs_pkg::NODE_W-1:0] + in_enodes_reg;
                        sum_reg  <= child_sum[ewcs_pkg::SUM_W] ? '1
                                    : child_sum[ewcs_pkg::SUM_W-1:0];
                    end
                    ewcs_pkg::CMD_SYNC:
                    begin
                        if (!is_sink_reg)
                        begin
                            if (!sync_done_reg)
                                local_clock_reg <= ewcs_pkg::CLK_W'(
                                    ({1'b0, local_clock_reg} + {1'b0, in_sclk_reg}) >> 1);
                            if (seen_inc == n)
                            begin
                                sync_seen_reg <= '0;
                                sync_done_reg <= 1'b0;
                            end
                            else
                            begin
                                sync_seen_reg <= seen_inc;
                                sync_done_reg <= 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.apply_avg)
                local_clock_reg <= ewcs_pkg::CLK_W'(
                    ({1'b0, local_clock_reg} + {1'b0, avg}) >> 1);
            if (cmd.wave_clear)
            begin
                sum_reg  <= '0;
                desc_reg <= '0;
                resp_reg <= '0;
                wave_reg <= 1'b0;
            end
            if (cmd.flood_init)
                fport_reg <= '0;
            else if (cmd.flood_adv)
                fport_reg <= fport_reg + 1'b1;
        end
    end

    // restoring divider, one quotient bit a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= ewcs_pkg::DIVCNT_W'(ewcs_pkg::DIVIDEND_W - 1);
        end
        else if (div_busy_reg)
        begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
            if (div_cnt_reg == '0)
                div_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= wave_total;
        end
        else if (div_busy_reg)
        begin
            rem_reg <= trial_ge ? ewcs_pkg::NODE_W'(trial - divisor)
                                : trial[ewcs_pkg::NODE_W-1:0];
            quo_reg <= {quo_reg[ewcs_pkg::DIVIDEND_W-2:0], trial_ge};
        end
    end

    // result fields
    always_comb
    begin
        o_kind  = ewcs_pkg::KIND_CLOCK;
        o_port  = '0;
        o_clock = '0;
        o_nodes = '0;
        o_conn  = 1'b0;
        case (cmd.emit_sel)
            ewcs_pkg::EM_CLOCK:
                o_clock = ewcs_pkg::SUM_W'(local_clock_reg);
            ewcs_pkg::EM_FLOOD:
            begin
                o_port = fport_reg;
                case (cmd.flood_mode)
                    ewcs_pkg::FL_SYNC:
                    begin
                        o_kind  = ewcs_pkg::KIND_SYNC;
                        o_clock = ewcs_pkg::SUM_W'(in_sclk_reg);
                    end
                    ewcs_pkg::FL_AVG:
                    begin
                        o_kind  = ewcs_pkg::KIND_SYNC;
                        o_clock = ewcs_pkg::SUM_W'(avg);
                    end
                    default:
                        o_kind = ewcs_pkg::KIND_EXPL;
                endcase
            end
            ewcs_pkg::EM_ECHO:
            begin
                o_kind  = ewcs_pkg::KIND_ECHO;
                o_port  = parent_reg;
                o_clock = echo_sum[ewcs_pkg::SUM_W] ? '1 : echo_sum[ewcs_pkg::SUM_W-1:0];
                o_nodes = desc_reg;
            end
            ewcs_pkg::EM_VERDICT:
            begin
                o_kind  = ewcs_pkg::KIND_VERDICT;
                o_nodes = desc_reg;
                o_conn  = (desc_plus == {1'b0, total_reg});
            end
            ewcs_pkg::EM_DIVERR:
                o_kind = ewcs_pkg::KIND_DIVERR;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid <= 1'b0;
        else if (cmd.emit)
            m_tvalid <= 1'b1;
        else if (m_tready)
            m_tvalid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            m_tuser <= o_kind;
            m_tlast <= cmd.emit_last;
            m_tdata <= {3'b000, o_conn, o_nodes, o_clock, o_port};
        end
    end

endmodule

>>> hdl/echo_wave_clock_sync_node_unit.sv
// A tick passes through accept, decode and report; its clock report is then held in
// the output register. A timer, explorer or sync flood passes through accept and decode
// and then sends one result per port. An explorer skips its parent's port, and wave
// completion adds a check step and then the echo.
// Sink wave completion: accept, decode, check, verdict, the serial divider (one quotient
// bit a cycle), a hand-off step, then one sync per port. Output stalls hold the sequence.
// Throughput: one transaction at a time; the next is taken once the last result of the
// previous one, if it has any, is in the output register.
// Reset: rst_n is asynchronous and active low; it clears all protocol state.
module echo_wave_clock_sync_node_unit (
    input  logic         clk,
    input  logic         rst_n,
    // configuration write port
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [15:0]  cfg_wdata,
    // input transactions
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // arrival_port, tick_increment, echo_clock,
                                    // echo_nodes, sync_clock (lowest bit up)
    input  logic [2:0]   s_tuser,   // cmd
    // result transactions
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // out_port, out_clock, out_nodes, connected
    output logic [2:0]   m_tuser,   // out_kind
    output logic         m_tlast    // last result of the input transaction
);

    ewcs_pkg::ewcs_cmd_t  cmd;
    ewcs_pkg::ewcs_stat_t st;

    // sequencer: decides which results to produce and in what order
    ewcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // state, divider and the output register that holds a result until taken
    ewcs_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

>>> hdl/ewcs_checker.sv
// Port-level checks of the echo-wave clock sync node, bound to the top level.
// Depends on ewcs_pkg.
module ewcs_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata,
    input logic [2:0]   m_tuser,
    input logic         m_tlast
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken during decode");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ewcs_pkg::KIND_DIVERR |-> m_tlast)
        else $error("divide error is not the final result");

    a_verdict_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ewcs_pkg::KIND_VERDICT |-> !m_tlast)
        else $error("verdict marked final");

endmodule

bind echo_wave_clock_sync_node_unit ewcs_checker u_ewcs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
